// File: design/bmpd_pkg.sv
package bmpd_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int COORD_W = 12;

    // header layout
    localparam logic [5:0] HDR_LAST   = 6'd53;
    localparam logic [5:0] OFS_WIDTH  = 6'd18;
    localparam logic [5:0] OFS_HEIGHT = 6'd22;
    localparam logic [5:0] OFS_DEPTH  = 6'd28;

    localparam logic [7:0]  SIG_B    = 8'h42;
    localparam logic [7:0]  SIG_M    = 8'h4D;
    localparam logic [15:0] DEPTH_24 = 16'd24;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXELS,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        ST_PIXEL,
        ST_BAD_SIG,
        ST_BAD_DEPTH,
        ST_BAD_DIM
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_word_t;

    typedef struct packed {
        status_t              status;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic [COORD_W-1:0]   column;
        logic [COORD_W-1:0]   row;
        logic                 last_pixel;
    } result_t;

endpackage

// File: design/bmpd_in_stage.sv
module bmpd_in_stage
    import bmpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic [7:0] data_byte,
    input  logic     start_of_file,
    input  logic     adv,
    output logic     fire,
    output in_word_t word
);

    logic     valid_reg;
    in_word_t word_reg;

    // hold the word while the downstream cannot take its result
    assign in_stall = valid_reg && !adv;
    assign fire     = valid_reg && adv;
    assign word     = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            word_reg.data_byte     <= data_byte;
            word_reg.start_of_file <= start_of_file;
        end
    end

endmodule

// File: design/bmpd_core.sv
module bmpd_core
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  in_word_t word,
    output logic     res_valid,
    output result_t  res
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    phase_t        phase_reg, phase_next;
    logic [5:0]    hcount_reg, hcount_next;
    logic          sig_reg, sig_next;
    logic [31:0]   width_reg, width_next;
    logic [31:0]   height_reg, height_next;
    logic [15:0]   depth_reg, depth_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [1:0]    bip_reg, bip_next;
    logic [1:0]    pad_reg, pad_next;
    logic [7:0]    blue_reg, blue_next;
    logic [7:0]    green_reg, green_next;

    always_comb
    begin
        logic [7:0]    b;
        logic [5:0]    n;
        logic [1:0]    wlane;
        logic [1:0]    hlane;
        logic          dlane;
        status_t       st;
        logic          emit;
        logic          end_row;
        logic          last;
        logic [CW-1:0] col_inc;
        logic [RW-1:0] row_inc;

        b = word.data_byte;
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        sig_next    = sig_reg;
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bip_next    = bip_reg;
        pad_next    = pad_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;

        emit    = 1'b0;
        end_row = 1'b0;
        last    = 1'b0;
        st      = ST_PIXEL;

        res.status     = ST_PIXEL;
        res.red        = '0;
        res.green      = '0;
        res.blue       = '0;
        res.column     = '0;
        res.row        = '0;
        res.last_pixel = 1'b0;

        // start of file: drop all capture state, this byte is header byte 0
        if (word.start_of_file)
        begin
            phase_next  = PH_HEADER;
            hcount_next = '0;
            sig_next    = 1'b0;
            width_next  = '0;
            height_next = '0;
            depth_next  = '0;
            col_next    = '0;
            row_next    = '0;
            bip_next    = '0;
            pad_next    = '0;
            blue_next   = '0;
            green_next  = '0;
        end

        n       = hcount_next;
        wlane   = 2'(n - OFS_WIDTH);
        hlane   = 2'(n - OFS_HEIGHT);
        dlane   = 1'(n - OFS_DEPTH);
        col_inc = col_next + 1'b1;
        row_inc = row_next + 1'b1;

        unique case (phase_next)
            PH_HEADER:
            begin
                if (n == 6'd0)
                begin
                    sig_next = (b == SIG_B);
                end
                else if (n == 6'd1)
                begin
                    sig_next = sig_next && (b == SIG_M);
                end
                else if (n >= OFS_WIDTH && n < OFS_WIDTH + 6'd4)
                begin
                    width_next[{wlane, 3'b000} +: 8] = b;
                end
                else if (n >= OFS_HEIGHT && n < OFS_HEIGHT + 6'd4)
                begin
                    height_next[{hlane, 3'b000} +: 8] = b;
                end
                else if (n >= OFS_DEPTH && n < OFS_DEPTH + 6'd2)
                begin
                    depth_next[{dlane, 3'b000} +: 8] = b;
                end

                if (n != HDR_LAST)
                begin
                    hcount_next = n + 6'd1;
                end
                else
                begin
                    hcount_next = '0;
                    // first failing check wins
                    priority if (!sig_next)
                        st = ST_BAD_SIG;
                    else if (depth_next != DEPTH_24)
                        st = ST_BAD_DEPTH;
                    else if (width_next == 32'd0 || width_next[31] ||
                             width_next > 32'(MAX_WIDTH) ||
                             height_next == 32'd0 || height_next[31] ||
                             height_next > 32'(MAX_HEIGHT))
                        st = ST_BAD_DIM;
                    else
                        st = ST_PIXEL;

                    if (st != ST_PIXEL)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        res.status = st;
                    end
                    else
                    begin
                        phase_next = PH_PIXELS;
                        col_next   = '0;
                        row_next   = '0;
                        bip_next   = '0;
                        pad_next   = '0;
                    end
                end
            end
            PH_PIXELS:
            begin
                if (pad_next != 2'd0)
                begin
                    pad_next = pad_next - 2'd1;
                    if (pad_next == 2'd0)
                        end_row = 1'b1;
                end
                else
                begin
                    unique case (bip_next)
                        2'd0:
                        begin
                            blue_next = b;
                            bip_next  = 2'd1;
                        end
                        2'd1:
                        begin
                            green_next = b;
                            bip_next   = 2'd2;
                        end
                        default:
                        begin
                            bip_next = 2'd0;
                            last = (col_inc == width_next[CW-1:0]) &&
                                   (row_inc == height_next[RW-1:0]);
                            emit           = 1'b1;
                            res.red        = b;
                            res.green      = green_next;
                            res.blue       = blue_next;
                            res.column     = COORD_W'(col_next);
                            res.row        = height_next[COORD_W-1:0] - 12'd1
                                             - COORD_W'(row_next);
                            res.last_pixel = last;
                            col_next       = col_inc;
                            if (last)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (col_inc == width_next[CW-1:0])
                            begin
                                if (width_next[1:0] != 2'd0)
                                    pad_next = width_next[1:0];
                                else
                                    end_row = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        if (end_row)
        begin
            col_next = '0;
            row_next = row_inc;
            if (row_inc == height_next[RW-1:0])
                phase_next = PH_IDLE;
        end

        res_valid = fire && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= '0;
            sig_reg    <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
            depth_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            bip_reg    <= '0;
            pad_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            sig_reg    <= sig_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            bip_reg    <= bip_next;
            pad_reg    <= pad_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
        end
    end

    a_err_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != ST_PIXEL |=> phase_reg == PH_IDLE)
        else $error("error result did not leave the decoder idle");

    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last_pixel |=> phase_reg == PH_IDLE)
        else $error("last pixel did not leave the decoder idle");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PIXELS |-> col_reg <= width_reg[CW-1:0])
        else $error("column counter beyond image width");

    a_bip_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PIXELS |-> bip_reg != 2'd3)
        else $error("byte-in-pixel counter out of range");

    a_pad_only_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PIXELS && pad_reg != 2'd0
        |-> col_reg == width_reg[CW-1:0] && bip_reg == 2'd0)
        else $error("padding skip outside of row end");

endmodule

// File: design/bmpd_out_stage.sv
module bmpd_out_stage
    import bmpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    output logic    adv,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_word
);

    logic    valid_reg;
    result_t word_reg;

    // advance whenever the result register is empty or being taken
    assign adv       = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && res_valid)
        begin
            word_reg <= res;
        end
    end

endmodule

// File: design/bmp24_stream_decoder_top.sv
// 24-bit uncompressed BMP stream decoder.
//
// Input channel: one file byte per word (data_byte), with start_of_file high
// on the first byte of a file. The 54-byte header is captured and checked on
// its last byte; a failed check yields one word with a nonzero status and
// the decoder then drops bytes until the next start_of_file.
// Output channel: one word per pixel (status 0) with red, green, blue, its
// column and top-down row, and last_pixel on the final pixel of the image.
// Row padding and bytes after the last pixel produce no word.
//
// Throughput: one byte per cycle while no result waits under out_stall;
// each byte needs only counter and field register updates between the input
// register and the result register, which captures any result it yields.
// Reset: asynchronous, clears all decode state; bytes after reset are taken
// as a header even without start_of_file.
// Stall: a result waiting under out_stall holds in the result register; a
// byte is still taken while the input register is empty, and in_stall is
// high while that register holds a byte, until the result is taken.
module bmp24_stream_decoder_top
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 start_of_file,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue,
    output logic [COORD_W-1:0]   column,
    output logic [COORD_W-1:0]   row,
    output logic                 last_pixel
);

    logic     adv;
    logic     fire;
    in_word_t word;
    logic     res_valid;
    result_t  res;
    result_t  out_word;

    bmpd_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .adv           (adv),
        .fire          (fire),
        .word          (word)
    );

    bmpd_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    bmpd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .adv       (adv),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign status     = out_word.status;
    assign red        = out_word.red;
    assign green      = out_word.green;
    assign blue       = out_word.blue;
    assign column     = out_word.column;
    assign row        = out_word.row;
    assign last_pixel = out_word.last_pixel;

endmodule

// File: dv/tb_bmp24_stream_decoder_top.sv
module tb_bmp24_stream_decoder_top;
    import bmpd_pkg::*;

    localparam logic [15:0] GOOD_SIG    = {SIG_M, SIG_B};
    localparam int          RANDOM_WORDS = 550;
    localparam int          CYCLE_LIMIT  = 1000000;

    typedef struct {
        in_word_t w;
        bit       drain;
        bit       quiet;
    } feed_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           data_byte;
    logic                 start_of_file;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           status;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [COORD_W-1:0]   column;
    logic [COORD_W-1:0]   row;
    logic                 last_pixel;

    feed_t   feed_q[$];
    result_t decoded_due[$];

    bit feed_quiet;
    bit feed_drain;
    bit quiet_now;
    bit in_accepted;
    int gap_left;
    int stall_left;
    int fails;
    int cycles;

    // decoder state as seen by the testbench
    phase_t      dec_phase;
    logic [5:0]  hdr_idx;
    bit          sig_ok;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [15:0] depth;
    logic [31:0] col;
    logic [31:0] frow;
    logic [1:0]  bip;
    logic [1:0]  pad_left;
    logic [7:0]  hold_b;
    logic [7:0]  hold_g;

    bmp24_stream_decoder_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .column        (column),
        .row           (row),
        .last_pixel    (last_pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_decode();
        dec_phase = PH_HEADER;
        hdr_idx   = '0;
        sig_ok    = 1'b0;
        img_w     = '0;
        img_h     = '0;
        depth     = '0;
        col       = '0;
        frow      = '0;
        bip       = '0;
        pad_left  = '0;
        hold_b    = '0;
        hold_g    = '0;
    endfunction

    function automatic bit dim_bad(input logic [31:0] v, input int maxv);
        return v == 0 || v[31] || v > 32'(maxv);
    endfunction

    function automatic void next_row();
        col  = '0;
        frow = frow + 1;
        if (frow >= img_h)
            dec_phase = PH_IDLE;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic sof);
        result_t     r;
        status_t     st;
        int          k;
        bit          is_last;
        logic [31:0] top_row;
        r = '0;
        if (sof)
            clear_decode();
        k = int'(hdr_idx);
        if (dec_phase == PH_HEADER)
        begin
            if (k == 0)
                sig_ok = (b == SIG_B);
            else if (k == 1)
                sig_ok = sig_ok && (b == SIG_M);
            else if (k >= OFS_WIDTH && k < OFS_WIDTH + 4)
                img_w[8*(k - OFS_WIDTH) +: 8] = b;
            else if (k >= OFS_HEIGHT && k < OFS_HEIGHT + 4)
                img_h[8*(k - OFS_HEIGHT) +: 8] = b;
            else if (k >= OFS_DEPTH && k < OFS_DEPTH + 2)
                depth[8*(k - OFS_DEPTH) +: 8] = b;

            if (hdr_idx != HDR_LAST)
                hdr_idx = hdr_idx + 6'd1;
            else
            begin
                hdr_idx = '0;
                // first failing check wins
                if (!sig_ok)
                    st = ST_BAD_SIG;
                else if (depth != DEPTH_24)
                    st = ST_BAD_DEPTH;
                else if (dim_bad(img_w, MAX_WIDTH_DEF) || dim_bad(img_h, MAX_HEIGHT_DEF))
                    st = ST_BAD_DIM;
                else
                    st = ST_PIXEL;
                if (st != ST_PIXEL)
                begin
                    dec_phase = PH_IDLE;
                    r.status = st;
                    decoded_due.push_back(r);
                end
                else
                begin
                    dec_phase = PH_PIXELS;
                    col       = '0;
                    frow      = '0;
                    bip       = '0;
                    pad_left  = '0;
                end
            end
        end
        else if (dec_phase == PH_PIXELS)
        begin
            if (pad_left != 0)
            begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 0)
                    next_row();
            end
            else if (bip == 0)
            begin
                hold_b = b;
                bip    = 2'd1;
            end
            else if (bip == 1)
            begin
                hold_g = b;
                bip    = 2'd2;
            end
            else
            begin
                bip     = 2'd0;
                is_last = (col + 1 == img_w) && (frow + 1 == img_h);
                top_row = img_h - 1 - frow;
                r.status     = ST_PIXEL;
                r.red        = b;
                r.green      = hold_g;
                r.blue       = hold_b;
                r.column     = col[COORD_W-1:0];
                r.row        = top_row[COORD_W-1:0];
                r.last_pixel = is_last;
                decoded_due.push_back(r);
                col = col + 1;
                if (is_last)
                    dec_phase = PH_IDLE;
                else if (col >= img_w)
                begin
                    if (img_w[1:0] != 0)
                        pad_left = img_w[1:0];
                    else
                        next_row();
                end
            end
        end
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // monitor: check taken result words, then predict from the taken byte
    always @(posedge clk)
    begin : mon
        result_t want;
        if (rst_n)
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
            begin
                if (out_valid && !out_stall)
                begin
                    if (decoded_due.size() == 0)
                    begin
                        $error("unexpected word: status %0d column %0d row %0d",
                               status, column, row);
                        fails++;
                    end
                    else
                    begin
                        want = decoded_due.pop_front();
                        check_field("status", want.status, status);
                        check_field("red", want.red, red);
                        check_field("green", want.green, green);
                        check_field("blue", want.blue, blue);
                        check_field("column", want.column, column);
                        check_field("row", want.row, row);
                        check_field("last_pixel", want.last_pixel, last_pixel);
                    end
                end
                in_accepted = in_valid && !in_stall;
                if (in_accepted)
                    decode_byte(data_byte, start_of_file);
            end
        end
    end

    // driver: byte side and result-side stall, both on the falling edge
    always @(negedge clk)
    begin : drv
        feed_t cur;
        logic  nv;
        if (rst_n)
        begin
            if (!in_valid || in_accepted)
            begin
                nv = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (feed_q.size() > 0 &&
                         !(feed_q[0].drain && decoded_due.size() != 0))
                begin
                    if (!feed_q[0].quiet && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(0, 5);
                    else
                    begin
                        cur = feed_q.pop_front();
                        data_byte     <= cur.w.data_byte;
                        start_of_file <= cur.w.start_of_file;
                        quiet_now = cur.quiet;
                        nv = 1'b1;
                    end
                end
                in_valid <= nv;
            end

            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet_now && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic push_byte(input logic [7:0] b, input bit sof);
        feed_t f;
        f.w.data_byte     = b;
        f.w.start_of_file = sof;
        f.drain = feed_drain;
        f.quiet = feed_quiet;
        feed_drain = 1'b0;
        feed_q.push_back(f);
    endtask

    // header (first hdr_len bytes of it) followed by body_len random bytes
    task automatic push_file(input bit sof, input logic [15:0] sig,
                             input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] bpp, input int hdr_len,
                             input int body_len);
        logic [7:0] b;
        for (int i = 0; i < hdr_len; i++)
        begin
            b = 8'($urandom);
            if (i < 2)
                b = sig[8*i +: 8];
            else if (i >= OFS_WIDTH && i < OFS_WIDTH + 4)
                b = w[8*(i - OFS_WIDTH) +: 8];
            else if (i >= OFS_HEIGHT && i < OFS_HEIGHT + 4)
                b = h[8*(i - OFS_HEIGHT) +: 8];
            else if (i >= OFS_DEPTH && i < OFS_DEPTH + 2)
                b = bpp[8*(i - OFS_DEPTH) +: 8];
            push_byte(b, sof && i == 0);
        end
        for (int i = 0; i < body_len; i++)
            push_byte(8'($urandom), 1'b0);
    endtask

    function automatic int image_bytes(input int w, input int h);
        return (w * 3 + w % 4) * h;
    endfunction

    function automatic logic [31:0] bad_dim();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return {1'b1, 31'($urandom)};
            default: return $urandom_range(MAX_WIDTH_DEF + 1, 32'h7fff_ffff);
        endcase
    endfunction

    initial
    begin : stim
        int          w;
        int          h;
        int          kind;
        int          goal;
        logic [31:0] ew;
        logic [31:0] eh;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        start_of_file = 1'b0;
        out_stall     = 1'b0;
        in_accepted   = 1'b0;
        quiet_now     = 1'b1;
        gap_left      = 0;
        stall_left    = 0;
        fails         = 0;
        cycles        = 0;
        feed_drain    = 1'b0;
        clear_decode();

        // first file carries no start mark; its padding falls into idle
        feed_quiet = 1'b1;
        push_file(1'b0, GOOD_SIG, 1, 1, DEPTH_24, 54, image_bytes(1, 1) + 2);
        push_file(1'b1, GOOD_SIG, 2, 2, DEPTH_24, 54, image_bytes(2, 2));
        feed_quiet = 1'b0;
        push_file(1'b1, GOOD_SIG, 3, 2, DEPTH_24, 54, image_bytes(3, 2));
        push_file(1'b1, GOOD_SIG, 4, 1, DEPTH_24, 54, image_bytes(4, 1));
        push_file(1'b1, GOOD_SIG, 5, 3, DEPTH_24, 54, image_bytes(5, 3));

        // header checks, each error followed by ignored bytes
        push_file(1'b1, {SIG_M, 8'h00}, 2, 2, DEPTH_24, 54, 3);
        push_file(1'b1, {8'hff, SIG_B}, 2, 2, DEPTH_24, 54, 3);
        push_file(1'b1, 16'h0000, 0, 2, 16'd32, 54, 3);
        push_file(1'b1, GOOD_SIG, 2, 2, 16'd32, 54, 3);
        push_file(1'b1, GOOD_SIG, 2, 2, 16'h0118, 54, 3);
        push_file(1'b1, GOOD_SIG, 0, 0, 16'd8, 54, 3);
        push_file(1'b1, GOOD_SIG, 0, 2, DEPTH_24, 54, 3);
        push_file(1'b1, GOOD_SIG, 2, 0, DEPTH_24, 54, 3);
        push_file(1'b1, GOOD_SIG, 32'h8000_0001, 2, DEPTH_24, 54, 3);
        push_file(1'b1, GOOD_SIG, 2, 32'hffff_ffff, DEPTH_24, 54, 3);
        push_file(1'b1, GOOD_SIG, MAX_WIDTH_DEF + 1, 2, DEPTH_24, 54, 3);
        push_file(1'b1, GOOD_SIG, 2, MAX_HEIGHT_DEF + 1, DEPTH_24, 54, 3);
        push_file(1'b1, GOOD_SIG, 32'h0001_0000, 1, DEPTH_24, 54, 3);

        // restart in the middle of a header and in the middle of the pixels
        push_file(1'b1, GOOD_SIG, 2, 1, DEPTH_24, 20, 0);
        push_file(1'b1, GOOD_SIG, 3, 3, DEPTH_24, 54, 10);
        feed_drain = 1'b1;
        push_file(1'b1, GOOD_SIG, 2, 1, DEPTH_24, 54, image_bytes(2, 1));

        // largest dimensions: tall image cut short, then a full-width row cut short
        push_file(1'b1, GOOD_SIG, 1, MAX_HEIGHT_DEF, DEPTH_24, 54, 14);
        push_file(1'b1, GOOD_SIG, MAX_WIDTH_DEF, 1, DEPTH_24, 54, 12);

        goal = feed_q.size() + RANDOM_WORDS;
        while (feed_q.size() < goal)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
            h = $urandom_range(1, 4);
            feed_quiet = (feed_q.size() > goal - 250) || ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 14) == 0)
                feed_drain = 1'b1;
            kind = $urandom_range(0, 19);
            if (kind < 14)
                push_file(1'b1, GOOD_SIG, w, h, DEPTH_24, 54,
                          image_bytes(w, h) + (($urandom_range(0, 3) == 0) ?
                                               $urandom_range(1, 4) : 0));
            else if (kind < 16)
            begin
                if ($urandom_range(0, 1) == 0)
                    push_file(1'b1, GOOD_SIG, w, h, DEPTH_24, $urandom_range(1, 53), 0);
                else
                    push_file(1'b1, GOOD_SIG, w, h, DEPTH_24, 54,
                              $urandom_range(0, image_bytes(w, h) - 1));
            end
            else if (kind < 18)
            begin
                ew = w;
                eh = h;
                case ($urandom_range(0, 3))
                    0: push_file(1'b1, 16'($urandom), ew, eh, DEPTH_24, 54, 2);
                    1: push_file(1'b1, GOOD_SIG, ew, eh, 16'($urandom), 54, 2);
                    2: push_file(1'b1, GOOD_SIG, bad_dim(), eh, DEPTH_24, 54, 2);
                    default: push_file(1'b1, GOOD_SIG, ew, bad_dim(), DEPTH_24, 54, 2);
                endcase
            end
            else
            begin
                for (int i = $urandom_range(1, 20); i > 0; i--)
                    push_byte(8'($urandom), $urandom_range(0, 15) == 0);
            end
        end

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || in_valid)
            @(posedge clk);
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
design/bmpd_pkg.sv
design/bmpd_in_stage.sv
design/bmpd_core.sv
design/bmpd_out_stage.sv
design/bmp24_stream_decoder_top.sv
dv/tb_bmp24_stream_decoder_top.sv
